// ----- hw/rtl/spfe_pkg.sv -----
package spfe_pkg;

  localparam int unsigned MaxFields    = 8;
  localparam int unsigned MaxStringLen = 256;

  localparam logic [7:0] HdrByte0 = 8'h50;  // 'P'
  localparam logic [7:0] HdrByte1 = 8'h49;  // 'I'

  // field type codes
  localparam logic [1:0] TypeU8  = 2'd0;
  localparam logic [1:0] TypeU16 = 2'd1;
  localparam logic [1:0] TypeU32 = 2'd2;
  localparam logic [1:0] TypeStr = 2'd3;

  // result kinds
  localparam logic [1:0] KindValue  = 2'd0;
  localparam logic [1:0] KindStrLen = 2'd1;
  localparam logic [1:0] KindStrChr = 2'd2;
  localparam logic [1:0] KindStatus = 2'd3;

  // packet status codes
  localparam logic [1:0] StOk      = 2'd0;
  localparam logic [1:0] StBadHdr  = 2'd1;
  localparam logic [1:0] StTrunc   = 2'd2;
  localparam logic [1:0] StTooLong = 2'd3;

  // register indexes
  localparam logic RegFieldCount = 1'b0;
  localparam logic RegFieldTypes = 1'b1;

  typedef enum logic [6:0] {
    PhHdr0  = 7'b0000001,
    PhHdr1  = 7'b0000010,
    PhNum   = 7'b0000100,
    PhSlen  = 7'b0001000,
    PhSdata = 7'b0010000,
    PhDone  = 7'b0100000,
    PhErr   = 7'b1000000
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [2:0]  field_index;
    logic [31:0] value;
    logic [7:0]  char_offset;
    logic [1:0]  status;
    logic        run_end;
  } result_t;

  // results caused by one input beat: first and optional second
  typedef struct packed {
    result_t r0;
    result_t r1;
    logic    v0;
    logic    v1;
  } parse_out_t;

  function automatic logic [1:0] type_of(logic [15:0] types, logic [2:0] idx);
    return types[{idx, 1'b0} +: 2];
  endfunction

endpackage

// ----- hw/rtl/spfe_parse.sv -----
module spfe_parse
  import spfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [3:0]  field_count,
  input  logic [15:0] field_types,
  output parse_out_t  po
);

  phase_t      phase, phase_next;
  logic [3:0]  current_field, current_field_next;
  logic [2:0]  bytes_in_field, bytes_in_field_next;
  logic [31:0] acc, acc_next;
  logic [15:0] string_remaining, string_remaining_next;
  logic [7:0]  string_position, string_position_next;
  logic [1:0]  error_code, error_code_next;

  logic [3:0]  count_eff;
  logic [3:0]  bf_idx;
  phase_t      bf_phase;
  logic [1:0]  cur_type;
  logic [2:0]  need;
  logic [2:0]  bif_inc;
  logic [31:0] acc_num, acc_len;
  logic [15:0] rem_dec;
  logic        byte_hit;
  result_t     byte_res, stat_res;

  assign count_eff = (field_count > 4'(MaxFields)) ? 4'(MaxFields) : field_count;

  // next field to start: field 0 after the header, otherwise the following one
  assign bf_idx   = (phase == PhHdr1) ? 4'd0 : current_field + 4'd1;
  assign bf_phase = (bf_idx >= count_eff) ? PhDone :
                    (type_of(field_types, bf_idx[2:0]) == TypeStr) ? PhSlen : PhNum;

  assign cur_type = type_of(field_types, current_field[2:0]);
  assign need     = (cur_type == TypeU8) ? 3'd1 : (cur_type == TypeU16) ? 3'd2 : 3'd4;
  assign bif_inc  = bytes_in_field + 3'd1;
  assign acc_num  = acc | (32'(data_byte) << {bytes_in_field[1:0], 3'b000});
  assign acc_len  = acc | (32'(data_byte) << {bytes_in_field[0], 3'b000});
  assign rem_dec  = string_remaining - 16'd1;

  always_comb begin
    phase_next            = phase;
    current_field_next    = current_field;
    bytes_in_field_next   = bytes_in_field;
    acc_next              = acc;
    string_remaining_next = string_remaining;
    string_position_next  = string_position;
    error_code_next       = error_code;
    byte_hit              = 1'b0;
    byte_res              = '0;
    stat_res              = '0;
    po                    = '0;

    if (accept) begin
      case (phase)
        PhHdr0: begin
          if (data_byte == HdrByte0) begin
            phase_next = PhHdr1;
          end else begin
            error_code_next = StBadHdr;
            phase_next      = PhErr;
          end
        end
        PhHdr1: begin
          if (data_byte == HdrByte1) begin
            current_field_next  = bf_idx;
            bytes_in_field_next = 3'd0;
            acc_next            = '0;
            phase_next          = bf_phase;
          end else begin
            error_code_next = StBadHdr;
            phase_next      = PhErr;
          end
        end
        PhNum: begin
          acc_next            = acc_num;
          bytes_in_field_next = bif_inc;
          if (bif_inc >= need) begin
            byte_hit                 = 1'b1;
            byte_res.kind            = KindValue;
            byte_res.field_index     = current_field[2:0];
            byte_res.value           = acc_num;
            current_field_next       = bf_idx;
            bytes_in_field_next      = 3'd0;
            acc_next                 = '0;
            phase_next               = bf_phase;
          end
        end
        PhSlen: begin
          acc_next            = acc_len;
          bytes_in_field_next = bif_inc;
          if (bif_inc >= 3'd2) begin
            byte_hit             = 1'b1;
            byte_res.kind        = KindStrLen;
            byte_res.field_index = current_field[2:0];
            byte_res.value       = {16'd0, acc_len[15:0]};
            if (acc_len[15:0] > 16'(MaxStringLen)) begin
              error_code_next = StTooLong;
              phase_next      = PhErr;
            end else if (acc_len[15:0] == 16'd0) begin
              current_field_next  = bf_idx;
              bytes_in_field_next = 3'd0;
              acc_next            = '0;
              phase_next          = bf_phase;
            end else begin
              string_remaining_next = acc_len[15:0];
              string_position_next  = 8'd0;
              phase_next            = PhSdata;
            end
          end
        end
        PhSdata: begin
          byte_hit              = 1'b1;
          byte_res.kind         = KindStrChr;
          byte_res.field_index  = current_field[2:0];
          byte_res.value        = 32'(data_byte);
          byte_res.char_offset  = string_position;
          string_position_next  = string_position + 8'd1;
          string_remaining_next = rem_dec;
          if (rem_dec == 16'd0) begin
            current_field_next  = bf_idx;
            bytes_in_field_next = 3'd0;
            acc_next            = '0;
            phase_next          = bf_phase;
          end
        end
        default: ;
      endcase

      if (last_byte) begin
        stat_res.kind    = KindStatus;
        stat_res.run_end = 1'b1;
        if (phase_next == PhDone)     stat_res.status = StOk;
        else if (phase_next == PhErr) stat_res.status = error_code_next;
        else                          stat_res.status = StTrunc;
        phase_next            = PhHdr0;
        current_field_next    = 4'd0;
        bytes_in_field_next   = 3'd0;
        acc_next              = '0;
        string_remaining_next = 16'd0;
        string_position_next  = 8'd0;
        error_code_next       = StOk;
      end

      if (byte_hit) begin
        po.r0         = byte_res;
        po.r0.run_end = !last_byte;
        po.v0         = 1'b1;
        po.r1         = stat_res;
        po.v1         = last_byte;
      end else if (last_byte) begin
        po.r0 = stat_res;
        po.v0 = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PhHdr0;
      current_field    <= 4'd0;
      bytes_in_field   <= 3'd0;
      acc              <= '0;
      string_remaining <= 16'd0;
      string_position  <= 8'd0;
      error_code       <= StOk;
    end else begin
      phase            <= phase_next;
      current_field    <= current_field_next;
      bytes_in_field   <= bytes_in_field_next;
      acc              <= acc_next;
      string_remaining <= string_remaining_next;
      string_position  <= string_position_next;
      error_code       <= error_code_next;
    end
  end

endmodule

// ----- hw/rtl/schema_packet_field_extractor_unit.sv -----
// Channel     Direction  Beat contents
// s_axis      in         tdata: data_byte; tlast: last_byte
// m_axis      out        tuser: kind; tdata: field_index, value, char_offset, status;
//                        tlast: run_end
// apb         in/out     0x0 field_count, 0x4 field_types
//
// One input byte per cycle while s_tready is high. Each byte is parsed in the cycle it is
// accepted and its results land in a result register, so they appear in the next cycle.
// A byte giving two results (the final byte of a packet that also yields a field result)
// holds the input while the second result drains from the pending slot.
// Input ready drops while a second result is pending, or while a result waits on m_tready.
// rst is synchronous, active high; it clears the parser state, the APB registers and the valid flags.
module schema_packet_field_extractor_unit
  import spfe_pkg::*;
(
  input  logic        clk,
  input  logic        rst,

  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tlast,

  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [2:0] field_index, [34:3] value, [42:35] char_offset,
                                 // [44:43] status, [47:45] zero
  output logic [1:0]  m_tuser,   // [1:0] kind
  output logic        m_tlast,

  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [3:0]  field_count;
  logic [15:0] field_types;
  logic        cfg_wr;

  parse_out_t  po;
  result_t     cur, pend;
  logic        cur_valid, pend_valid;
  logic        in_acc, out_take;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == RegFieldTypes) ? {16'd0, field_types} : {28'd0, field_count};

  always_ff @(posedge clk) begin
    if (rst) begin
      field_count <= 4'd0;
      field_types <= 16'd0;
    end else if (cfg_wr) begin
      if (paddr[2] == RegFieldCount) field_count <= pwdata[3:0];
      else                           field_types <= pwdata[15:0];
    end
  end

  spfe_parse u_parse (
    .clk         (clk),
    .rst         (rst),
    .accept      (in_acc),
    .data_byte   (s_tdata),
    .last_byte   (s_tlast),
    .field_count (field_count),
    .field_types (field_types),
    .po          (po)
  );

  // result register plus one pending slot for the second result of a beat
  assign s_tready = !pend_valid && (!cur_valid || m_tready);
  assign in_acc   = s_tvalid & s_tready;
  assign out_take = m_tvalid & m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (in_acc && po.v0) begin
      cur_valid  <= 1'b1;
      pend_valid <= po.v1;
    end else if (out_take) begin
      cur_valid  <= pend_valid;
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && po.v0) begin
      cur  <= po.r0;
      pend <= po.r1;
    end else if (out_take && pend_valid) begin
      cur <= pend;
    end
  end

  assign m_tvalid = cur_valid;
  assign m_tuser  = cur.kind;
  assign m_tlast  = cur.run_end;
  assign m_tdata  = {3'd0, cur.status, cur.char_offset, cur.value, cur.field_index};

endmodule
